### rtl/tmp_pkg.sv
// Shared constants and types for the trapezoid motion profile generator.
package tmp_pkg;

  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RAMP_TIME   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED   = 2'd2;

  localparam logic [15:0] MS_PER_S  = 16'd1000;
  localparam logic [15:0] POS_SCALE = 16'd2000;
  // 65536 * 2000: at or above this the reported position saturates
  localparam logic [47:0] POS_SAT   = 48'd131072000;

  typedef struct packed {
    logic [31:0] num;   // numerator, left aligned to bits
    logic [31:0] den;
    logic [5:0]  bits;
  } div_req_t;

  typedef struct packed {
    logic [16:0] a;
    logic [15:0] b;
  } mul_req_t;

endpackage

### rtl/tmp_if.sv
// Request and response channel interfaces.
interface tmp_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] distance;
  modport source(output valid, req_type, distance, input ready);
  modport sink(input valid, req_type, distance, output ready);
endinterface

interface tmp_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic [15:0] speed;
  logic [15:0] step_count;
  logic        idle;
  modport source(output valid, position, speed, step_count, idle, input ready);
  modport sink(input valid, position, speed, step_count, idle, output ready);
endinterface

### rtl/tmp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tmp_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tmp_pkg::div_req_t req,
  output logic              done,
  output logic [31:0]       quo
);
  import tmp_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] den;
  logic [32:0] shifted;
  logic [33:0] diff;

  assign shifted = {rem, quo[31]};
  assign diff    = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= req.bits;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= diff[33] ? shifted[31:0] : diff[31:0];
      quo <= {quo[30:0], ~diff[33]};
    end
  end

endmodule

### rtl/tmp_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module tmp_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tmp_pkg::mul_req_t req,
  output logic              done,
  output logic [32:0]       prod
);
  import tmp_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [32:0] a;
  logic [15:0] b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= {16'b0, req.a};
      b    <= req.b;
      prod <= '0;
    end else if (busy) begin
      if (b[0]) begin
        prod <= prod + a;
      end
      a <= {a[31:0], 1'b0};
      b <= {1'b0, b[15:1]};
    end
  end

endmodule

### rtl/trapezoid_motion_profile.sv
// Trapezoid motion profile generator: top level and sequencer.
// Start word: three serial divides of 16, 16 and 26 bits, two serial multiplies
// and a 27-bit position divide. Tick word: one serial multiply and one position
// divide; a saturated position skips its divide. One word at a time; a new
// word is taken while the previous response waits. Synchronous reset restores
// register defaults and an idle generator; nothing needs clearing afterwards.
module trapezoid_motion_profile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tmp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [15:0]                   cfg_data,
  tmp_req_if.sink                       req,
  tmp_rsp_if.source                     rsp
);
  import tmp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RAMP  = 10'b0000000010,
    S_STEP  = 10'b0000000100,
    S_DMUL  = 10'b0000001000,
    S_VMUL  = 10'b0000010000,
    S_BRAKE = 10'b0000100000,
    S_TMUL  = 10'b0001000000,
    S_PCHK  = 10'b0010000000,
    S_PDIV  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t      state;

  logic [15:0] tick_period;
  logic [15:0] ramp_time;
  logic [15:0] max_speed;

  logic [15:0] tick_index;
  logic [15:0] cur_speed;
  logic [47:0] pos_accum;
  logic [15:0] ramp_steps;
  logic [15:0] speed_step;
  logic [15:0] brake_index;
  logic [15:0] end_index;
  logic [15:0] target_dist;
  logic        idle_flag;
  logic [15:0] tick_latch;

  logic        running;
  logic [25:0] num_hold;
  logic [15:0] pos_res;

  logic        out_valid;
  logic [15:0] out_position;
  logic [15:0] out_speed;
  logic [15:0] out_step;
  logic        out_idle;

  logic        div_start;
  div_req_t    div_req;
  logic        div_done;
  logic [31:0] div_quo;
  logic        mul_start;
  mul_req_t    mul_req;
  logic        mul_done;
  logic [32:0] mul_prod;

  logic        accept;
  logic [15:0] teff;
  logic [15:0] vmax_eff;
  logic [15:0] ti_next;
  logic [15:0] spd_next;
  logic        run_next;
  logic [16:0] spd_sum;
  logic [15:0] rs_fix;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid      = out_valid;
  assign rsp.position   = out_position;
  assign rsp.speed      = out_speed;
  assign rsp.step_count = out_step;
  assign rsp.idle       = out_idle;

  assign teff     = (tick_period == 16'd0) ? 16'd1 : tick_period;
  assign vmax_eff = (max_speed == 16'd0) ? 16'd1 : max_speed;
  assign ti_next  = tick_index + 16'd1;
  assign rs_fix   = (div_quo[15:0] == 16'd0) ? 16'd1 : div_quo[15:0];
  assign spd_sum  = {1'b0, spd_next} + {1'b0, cur_speed};

  always_comb begin
    run_next = 1'b1;
    if (ti_next <= ramp_steps) begin
      spd_next = cur_speed + speed_step;
    end else if (ti_next <= brake_index) begin
      spd_next = max_speed;
    end else if (ti_next <= end_index) begin
      spd_next = cur_speed - speed_step;
    end else begin
      spd_next = 16'd0;
      run_next = 1'b0;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    mul_start = 1'b0;
    mul_req   = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!req.req_type) begin
            div_start    = 1'b1;
            div_req.num  = {ramp_time, 16'b0};
            div_req.den  = {16'b0, teff};
            div_req.bits = 6'd16;
          end else begin
            mul_start = 1'b1;
            mul_req.a = run_next ? spd_sum : {1'b0, target_dist};
            mul_req.b = run_next ? tick_latch : POS_SCALE;
          end
        end
      end
      S_RAMP: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_req.num  = {max_speed, 16'b0};
          div_req.den  = {16'b0, rs_fix};
          div_req.bits = 6'd16;
        end
      end
      S_STEP: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_req.a = {1'b0, target_dist};
          mul_req.b = MS_PER_S;
        end
      end
      S_DMUL: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_req.a = {1'b0, vmax_eff};
          mul_req.b = tick_latch;
        end
      end
      S_VMUL: begin
        if (mul_done) begin
          div_start    = 1'b1;
          div_req.num  = {num_hold, 6'b0};
          div_req.den  = mul_prod[31:0];
          div_req.bits = 6'd26;
        end
      end
      S_PCHK: begin
        if (pos_accum < POS_SAT) begin
          div_start    = 1'b1;
          div_req.num  = {pos_accum[26:0], 5'b0};
          div_req.den  = {16'b0, POS_SCALE};
          div_req.bits = 6'd27;
        end
      end
      S_BRAKE, S_TMUL, S_PDIV, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= 16'd1;
      ramp_time   <= 16'd0;
      max_speed   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_PERIOD: tick_period <= cfg_data;
        REG_RAMP_TIME:   ramp_time   <= cfg_data;
        REG_MAX_SPEED:   max_speed   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      tick_index  <= '0;
      cur_speed   <= '0;
      pos_accum   <= '0;
      ramp_steps  <= '0;
      speed_step  <= '0;
      brake_index <= '0;
      end_index   <= '0;
      target_dist <= '0;
      idle_flag   <= 1'b1;
      tick_latch  <= '0;
    end else begin
      if (rsp.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!req.req_type) begin
              target_dist <= req.distance;
              tick_latch  <= teff;
              tick_index  <= '0;
              cur_speed   <= '0;
              pos_accum   <= '0;
              idle_flag   <= 1'b0;
              state       <= S_RAMP;
            end else begin
              tick_index <= ti_next;
              cur_speed  <= spd_next;
              idle_flag  <= ~run_next;
              running    <= run_next;
              state      <= S_TMUL;
            end
          end
        end
        S_RAMP: begin
          if (div_done) begin
            ramp_steps <= rs_fix;
            state      <= S_STEP;
          end
        end
        S_STEP: begin
          if (div_done) begin
            speed_step <= div_quo[15:0];
            state      <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mul_done) begin
            num_hold <= mul_prod[25:0];
            state    <= S_VMUL;
          end
        end
        S_VMUL: begin
          if (mul_done) begin
            state <= S_BRAKE;
          end
        end
        S_BRAKE: begin
          if (div_done) begin
            brake_index <= div_quo[15:0];
            end_index   <= div_quo[15:0] + ramp_steps;
            state       <= S_PCHK;
          end
        end
        S_TMUL: begin
          if (mul_done) begin
            // running: trapezoid step added; stopped: snap to the distance
            pos_accum <= running ? (pos_accum + {15'b0, mul_prod}) : {15'b0, mul_prod};
            state     <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (pos_accum < POS_SAT) begin
            state <= S_PDIV;
          end else begin
            pos_res <= 16'hFFFF;
            state   <= S_OUT;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            pos_res <= div_quo[15:0];
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_position <= pos_res;
            out_speed    <= cur_speed;
            out_step     <= tick_index;
            out_idle     <= idle_flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tmp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  tmp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

endmodule
